// ----- rtl/core/ftpid_pkg.sv -----
// ----------------------------------------------------------------------------
// ftpid_pkg: shared definitions for the fan temperature PID controller
// Widths, register reset values, fixed-point formats and register indexes.
// ----------------------------------------------------------------------------
package ftpid_pkg;

  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned OFFS_W   = 8;
  localparam int unsigned THR_W    = 11;
  localparam int unsigned POWER_W  = 8;
  localparam int unsigned INTEG_W  = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
  localparam int unsigned TEMP_FRAC = 4;
  localparam int unsigned INT_FRAC  = 12;
  localparam int unsigned OUT_FRAC  = 20;
  localparam int unsigned OUT_MAX   = 255;

  localparam logic [GAIN_W-1:0] KP_RESET  = 16'd1536;
  localparam logic [GAIN_W-1:0] KI_RESET  = 16'd205;
  localparam logic [GAIN_W-1:0] KD_RESET  = 16'd102;
  localparam logic [OFFS_W-1:0] OFFS_RESET = 8'd32;
  localparam logic [THR_W-1:0]  THR_RESET  = 11'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_OFFSET    = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_index_e;

endpackage

// ----- rtl/core/fan_temp_pid_controller.sv -----
// ----------------------------------------------------------------------------
// fan_temp_pid_controller: fan drive PID with derivative on measurement
// Glitch filter on the sample, then one PID update per transaction.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle while in_stall_o is low; each result
// passes the input register, then the result register. The input register
// feeds a single stage holding the glitch filter, the three gain multipliers,
// the integrator clamp and the output clamp, which writes the result register
// and the controller state in the same cycle. The result register holds under
// stall and the input side keeps taking transactions until both registers are
// full. Gains use GAIN_FRAC_BITS fraction bits; configuration writes take
// effect at once and are meant for idle periods.
module fan_temp_pid_controller #(
  parameter int unsigned GAIN_FRAC_BITS = ftpid_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ftpid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ftpid_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ftpid_pkg::TEMP_W-1:0] sample_temp_i,
  input  logic signed [ftpid_pkg::TEMP_W-1:0] ambient_temp_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ftpid_pkg::POWER_W-1:0]       fan_power_o,
  output logic                                fan_on_o,
  output logic                                sample_rejected_o
);
  import ftpid_pkg::*;

  localparam int unsigned PROD_FRAC = GAIN_FRAC_BITS + TEMP_FRAC;
  localparam int unsigned INC_RSH   = (PROD_FRAC >= INT_FRAC) ? PROD_FRAC - INT_FRAC : 0;
  localparam int unsigned INC_LSH   = (PROD_FRAC < INT_FRAC) ? INT_FRAC - PROD_FRAC : 0;
  localparam int unsigned SCALE_SH  = OUT_FRAC - PROD_FRAC;
  localparam int unsigned INT_SH    = OUT_FRAC - INT_FRAC;
  localparam int unsigned ERR_W     = TEMP_W + 2;
  localparam int unsigned PROD_W    = GAIN_W + TEMP_W;
  localparam int unsigned DPROD_W   = GAIN_W + TEMP_W + 2;
  localparam int unsigned ACC_W     = PROD_W + INC_LSH + 2;
  localparam int unsigned SUM_W     = DPROD_W + SCALE_SH + 4;
  localparam logic [ACC_W-1:0] IMAX = ACC_W'(OUT_MAX) << INT_FRAC;
  localparam logic signed [SUM_W-1:0] OMAX = SUM_W'(OUT_MAX) << OUT_FRAC;

  logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [OFFS_W-1:0] offset_q;
  logic [THR_W-1:0]  thresh_q;

  logic                     in_valid_q;
  logic signed [TEMP_W-1:0] temp_q, amb_q;
  logic                     out_valid_q;
  logic [POWER_W-1:0]       power_q;
  logic                     rejected_q;

  logic signed [TEMP_W-1:0] stored_q, prev_q;
  logic                     stored_valid_q;
  logic [INTEG_W-1:0]       integ_q;

  logic advance, fire, accept;

  logic signed [TEMP_W:0]   diff;
  logic [TEMP_W:0]          diff_abs;
  logic                     reject;
  logic signed [TEMP_W-1:0] filt;
  logic signed [ERR_W-1:0]  err;
  logic                     err_pos;
  logic [TEMP_W-1:0]        err_u;
  logic [PROD_W-1:0]        i_prod, p_prod;
  logic signed [TEMP_W:0]   din;
  logic signed [GAIN_W:0]   kd_s;
  logic signed [DPROD_W-1:0] d_prod;
  logic [ACC_W-1:0]         inc, acc;
  logic [INTEG_W-1:0]       integ_d;
  logic signed [SUM_W-1:0]  p_term, i_term, d_term, sum;
  logic [POWER_W-1:0]       power_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // glitch filter
  assign diff     = {temp_q[TEMP_W-1], temp_q} - {stored_q[TEMP_W-1], stored_q};
  assign diff_abs = diff[TEMP_W] ? (TEMP_W+1)'(-diff) : diff;
  assign reject   = stored_valid_q && (diff_abs > (TEMP_W+1)'(thresh_q));
  assign filt     = reject ? stored_q : temp_q;

  // error
  assign err = ERR_W'(filt) - ERR_W'(amb_q) - $signed(ERR_W'(offset_q));
  assign err_pos = !err[ERR_W-1] && (err != '0);
  assign err_u   = err[TEMP_W-1:0];

  // integrator
  assign i_prod  = PROD_W'(gain_i_q) * PROD_W'(err_u);
  assign inc     = (ACC_W'(i_prod) << INC_LSH) >> INC_RSH;
  assign acc     = ACC_W'(integ_q) + inc;
  assign integ_d = (acc > IMAX) ? IMAX[INTEG_W-1:0] : acc[INTEG_W-1:0];

  // output sum
  assign p_prod = PROD_W'(gain_p_q) * PROD_W'(err_u);
  assign din    = {filt[TEMP_W-1], filt} - {prev_q[TEMP_W-1], prev_q};
  assign kd_s   = $signed({1'b0, gain_d_q});
  assign d_prod = kd_s * din;
  assign p_term = $signed(SUM_W'(p_prod)) <<< SCALE_SH;
  assign d_term = SUM_W'(d_prod) <<< SCALE_SH;
  assign i_term = $signed(SUM_W'(integ_d)) <<< INT_SH;
  assign sum    = p_term + i_term - d_term;

  always_comb begin
    priority if (!err_pos || sum[SUM_W-1]) begin
      power_d = '0;
    end else if (sum > OMAX) begin
      power_d = POWER_W'(OUT_MAX);
    end else begin
      power_d = sum[OUT_FRAC +: POWER_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= KP_RESET;
      gain_i_q <= KI_RESET;
      gain_d_q <= KD_RESET;
      offset_q <= OFFS_RESET;
      thresh_q <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_GAIN_P:    gain_p_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:    gain_i_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:    gain_d_q <= cfg_data_i[GAIN_W-1:0];
        CFG_OFFSET:    offset_q <= cfg_data_i[OFFS_W-1:0];
        CFG_THRESHOLD: thresh_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      stored_q       <= '0;
      stored_valid_q <= 1'b0;
      integ_q        <= '0;
      prev_q         <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        stored_q       <= filt;
        stored_valid_q <= 1'b1;
        if (err_pos) begin
          integ_q <= integ_d;
          prev_q  <= filt;
        end else begin
          integ_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      temp_q <= sample_temp_i;
      amb_q  <= ambient_temp_i;
    end
    if (fire) begin
      power_q    <= power_d;
      rejected_q <= reject;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign fan_power_o       = power_q;
  assign fan_on_o          = power_q != '0;
  assign sample_rejected_o = rejected_q;

endmodule
